[hw/rtl/ssb_pkg.sv]
// shared constants and types for the scaled sprite blitter
`default_nettype none

package ssb_pkg;

    localparam int MAX_DIM_DEF   = 2048;
    localparam int MAX_SCALE_DEF = 8;

    localparam int COORD_W    = 11;
    localparam int COLOR_W    = 32;
    localparam int SCALE_W    = 4;
    localparam int SIZE_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    localparam int M_X_LO     = 0;
    localparam int M_Y_LO     = COORD_W;
    localparam int M_COLOR_LO = 2 * COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECT_WIDTH      = 3'd0,
        REG_RECT_HEIGHT     = 3'd1,
        REG_DEST_ORIGIN_X   = 3'd2,
        REG_DEST_ORIGIN_Y   = 3'd3,
        REG_SCALE_FACTOR    = 3'd4,
        REG_DEST_WIDTH      = 3'd5,
        REG_DEST_HEIGHT     = 3'd6,
        REG_TRANSPARENT_KEY = 3'd7
    } t_cfg_reg;

endpackage

`default_nettype wire

[hw/rtl/scaled_sprite_blitter.sv]
// scaled sprite blitter: color-keyed integer scale of a pixel stream into destination writes
//
// channel  dir  handshake                         payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready   tdata = pixel_color
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready   tdata = write_x, write_y, write_color;
//                                                 tlast = write_last
// cfg      in   i_cfg_we                          i_cfg_index, i_cfg_data
//
// one destination write per cycle while m_axis is ready: an opaque pixel gives nc*nr writes in the cell walker,
// nc and nr being the unclipped columns and rows of its block (scale squared when unclipped)
// transparent pixels are dropped at the input; a fully clipped pixel passes the input stage
// and emits nothing
// pipeline: input register, cell walker, output register
// reset is synchronous; it empties all stages and returns the source position to zero
// a stall on m_axis holds the walker; the input stage still takes pixels until one opaque
// pixel waits in it
`default_nettype none

module scaled_sprite_blitter #(
    parameter int MAX_DIM   = ssb_pkg::MAX_DIM_DEF,
    parameter int MAX_SCALE = ssb_pkg::MAX_SCALE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [ssb_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,   // pixel_color
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [ssb_pkg::M_TDATA_W-1:0]           o_m_axis_tdata,   // write_x, write_y,
                                                                      // write_color, 2'b0
    output logic                                    o_m_axis_tlast,
    input  wire logic                               i_cfg_we,
    input  wire logic [ssb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ssb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CRD = ssb_pkg::COORD_W;
    localparam int CLR = ssb_pkg::COLOR_W;
    localparam int SCL = ssb_pkg::SCALE_W;
    localparam int SZ  = ssb_pkg::SIZE_W;
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CW  = (DW > CRD + SCL) ? DW : CRD + SCL;
    localparam int SCW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // configuration
    logic [SZ-1:0]  r_rect_width;
    logic [SZ-1:0]  r_rect_height;
    logic [CRD-1:0] r_dest_origin_x;
    logic [CRD-1:0] r_dest_origin_y;
    logic [SCL-1:0] r_scale_factor;
    logic [SZ-1:0]  r_dest_width;
    logic [SZ-1:0]  r_dest_height;
    logic [CLR-1:0] r_transparent_key;

    // source position
    logic [CRD-1:0] r_src_col;
    logic [CRD-1:0] r_src_row;
    logic [CRD-1:0] n_src_col;
    logic [CRD-1:0] n_src_row;

    // input stage
    logic           r_a_valid;
    logic [CLR-1:0] r_a_color;
    logic [CW-1:0]  r_a_bx;
    logic [CW-1:0]  r_a_by;

    // cell walker
    logic           r_b_valid;
    logic [CLR-1:0] r_b_color;
    logic [CRD-1:0] r_b_x0;
    logic [CRD-1:0] r_b_x;
    logic [CRD-1:0] r_b_y;
    logic [SCW-1:0] r_b_c;
    logic [SCW-1:0] r_b_r;
    logic [SCW-1:0] r_b_cmax;
    logic [SCW-1:0] r_b_rmax;

    // output register
    logic           r_o_valid;
    logic [CRD-1:0] r_o_x;
    logic [CRD-1:0] r_o_y;
    logic [CLR-1:0] r_o_color;
    logic           r_o_last;

    logic [CW-1:0]  w_rect;
    logic [CW-1:0]  h_rect;
    logic [CW-1:0]  w_dest;
    logic [CW-1:0]  h_dest;
    logic [SCL-1:0] scale;
    logic [CW-1:0]  col_inc;
    logic [CW-1:0]  row_inc;
    logic [CRD+SCL-1:0] prod_x;
    logic [CRD+SCL-1:0] prod_y;
    logic [CW-1:0]  rem_x;
    logic [CW-1:0]  rem_y;
    logic [SCL-1:0] ncols;
    logic [SCL-1:0] nrows;
    logic           a_hit;

    logic s_fire;
    logic o_free;
    logic b_fire;
    logic b_last;
    logic b_done;
    logic b_free;
    logic a_take;

    // effective sizes
    always_comb begin
        if (r_rect_width == '0) begin
            w_rect = CW'(1);
        end else if (CW'(r_rect_width) > CW'(MAX_DIM)) begin
            w_rect = CW'(MAX_DIM);
        end else begin
            w_rect = CW'(r_rect_width);
        end
        if (r_rect_height == '0) begin
            h_rect = CW'(1);
        end else if (CW'(r_rect_height) > CW'(MAX_DIM)) begin
            h_rect = CW'(MAX_DIM);
        end else begin
            h_rect = CW'(r_rect_height);
        end
        if (r_scale_factor == '0) begin
            scale = SCL'(1);
        end else if (r_scale_factor > SCL'(MAX_SCALE)) begin
            scale = SCL'(MAX_SCALE);
        end else begin
            scale = r_scale_factor;
        end
        w_dest = (CW'(r_dest_width) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(r_dest_width);
        h_dest = (CW'(r_dest_height) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(r_dest_height);
    end

    // position advance and block origin
    assign col_inc = CW'(r_src_col) + CW'(1);
    assign row_inc = CW'(r_src_row) + CW'(1);
    assign prod_x  = (CRD+SCL)'(r_src_col) * (CRD+SCL)'(scale);
    assign prod_y  = (CRD+SCL)'(r_src_row) * (CRD+SCL)'(scale);

    always_comb begin
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        if (col_inc >= w_rect) begin
            n_src_col = '0;
            n_src_row = (row_inc >= h_rect) ? '0 : row_inc[CRD-1:0];
        end else begin
            n_src_col = col_inc[CRD-1:0];
        end
    end

    // clipping of the block held in the input stage
    assign rem_x = w_dest - r_a_bx;
    assign rem_y = h_dest - r_a_by;

    always_comb begin
        if (r_a_bx >= w_dest) begin
            ncols = '0;
        end else if (rem_x >= CW'(scale)) begin
            ncols = scale;
        end else begin
            ncols = rem_x[SCL-1:0];
        end
        if (r_a_by >= h_dest) begin
            nrows = '0;
        end else if (rem_y >= CW'(scale)) begin
            nrows = scale;
        end else begin
            nrows = rem_y[SCL-1:0];
        end
        a_hit = (ncols != '0) && (nrows != '0);
    end

    // flow control
    assign o_free = !r_o_valid || i_m_axis_tready;
    assign b_last = (r_b_c == r_b_cmax) && (r_b_r == r_b_rmax);
    assign b_fire = r_b_valid && o_free;
    assign b_done = b_fire && b_last;
    assign b_free = !r_b_valid || b_done;
    assign a_take = r_a_valid && b_free;
    assign o_s_axis_tready = !r_a_valid || a_take;
    assign s_fire = i_s_axis_tvalid && o_s_axis_tready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_width      <= SZ'(1);
            r_rect_height     <= SZ'(1);
            r_dest_origin_x   <= '0;
            r_dest_origin_y   <= '0;
            r_scale_factor    <= SCL'(1);
            r_dest_width      <= SZ'(2048);
            r_dest_height     <= SZ'(2048);
            r_transparent_key <= '0;
            r_src_col         <= '0;
            r_src_row         <= '0;
            r_a_valid         <= 1'b0;
            r_b_valid         <= 1'b0;
            r_o_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (ssb_pkg::t_cfg_reg'(i_cfg_index))
                    ssb_pkg::REG_RECT_WIDTH:      r_rect_width      <= i_cfg_data[SZ-1:0];
                    ssb_pkg::REG_RECT_HEIGHT:     r_rect_height     <= i_cfg_data[SZ-1:0];
                    ssb_pkg::REG_DEST_ORIGIN_X:   r_dest_origin_x   <= i_cfg_data[CRD-1:0];
                    ssb_pkg::REG_DEST_ORIGIN_Y:   r_dest_origin_y   <= i_cfg_data[CRD-1:0];
                    ssb_pkg::REG_SCALE_FACTOR:    r_scale_factor    <= i_cfg_data[SCL-1:0];
                    ssb_pkg::REG_DEST_WIDTH:      r_dest_width      <= i_cfg_data[SZ-1:0];
                    ssb_pkg::REG_DEST_HEIGHT:     r_dest_height     <= i_cfg_data[SZ-1:0];
                    ssb_pkg::REG_TRANSPARENT_KEY: r_transparent_key <= i_cfg_data[CLR-1:0];
                    default: ;
                endcase
            end
            if (s_fire) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
            end
            if (o_s_axis_tready) begin
                r_a_valid <= s_fire && (i_s_axis_tdata[CLR-1:0] != r_transparent_key);
            end
            if (b_free) begin
                r_b_valid <= a_take && a_hit;
            end
            if (o_free) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_color <= i_s_axis_tdata[CLR-1:0];
            r_a_bx    <= CW'(r_dest_origin_x) + CW'(prod_x);
            r_a_by    <= CW'(r_dest_origin_y) + CW'(prod_y);
        end
        if (b_free) begin
            r_b_color <= r_a_color;
            r_b_x0    <= r_a_bx[CRD-1:0];
            r_b_x     <= r_a_bx[CRD-1:0];
            r_b_y     <= r_a_by[CRD-1:0];
            r_b_c     <= '0;
            r_b_r     <= '0;
            r_b_cmax  <= SCW'(ncols - SCL'(1));
            r_b_rmax  <= SCW'(nrows - SCL'(1));
        end else if (b_fire) begin
            if (r_b_c == r_b_cmax) begin
                r_b_c <= '0;
                r_b_x <= r_b_x0;
                r_b_r <= r_b_r + SCW'(1);
                r_b_y <= r_b_y + CRD'(1);
            end else begin
                r_b_c <= r_b_c + SCW'(1);
                r_b_x <= r_b_x + CRD'(1);
            end
        end
        if (b_fire) begin
            r_o_x     <= r_b_x;
            r_o_y     <= r_b_y;
            r_o_color <= r_b_color;
            r_o_last  <= b_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {2'b00, r_o_color, r_o_y, r_o_x};

endmodule

`default_nettype wire

[hw/rtl/ssb_checker.sv]
// port-level checker for the scaled sprite blitter, bound to the top level
`default_nettype none

module ssb_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [ssb_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input wire logic                            o_m_axis_tlast
);

    localparam int CLO = ssb_pkg::M_COLOR_LO;
    localparam int CHI = ssb_pkg::M_COLOR_LO + ssb_pkg::COLOR_W - 1;

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // stalled output transaction holds
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    // a pixel's writes come without gaps and keep the pixel color
    a_block_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tdata[CHI:CLO] == $past(o_m_axis_tdata[CHI:CLO])))
        else $error("gap or color change inside a pixel block");

endmodule

bind scaled_sprite_blitter ssb_checker u_ssb_checker (.*);

`default_nettype wire
